/* rtl/core/mau_pkg.sv */
// ----------------------------------------------------------------------------
// modular arithmetic unit package
// command codes, field widths and the reset modulus
// ----------------------------------------------------------------------------
`default_nettype none
package mau_pkg;
    localparam int DATA_W   = 31;
    localparam int BRAW_W   = 64;
    localparam int CMD_W    = 3;
    localparam int EXP_BITS_DEF = 64;
    localparam logic [DATA_W-1:0] MOD_RESET = 31'd998244353;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POW = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INV = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd5;
    localparam logic [CMD_W-1:0] CMD_EQ  = 3'd6;
endpackage
`default_nettype wire

/* rtl/core/modular_arithmetic_unit.sv */
// sequence, input beat to result beat: add, sub, equal and undefined commands run the
//   bit-serial reduction of operand a, then of operand b, then the dispatch state; mul adds one serial product
// pow: per exponent bit, a product when the bit is set, then a squaring; inverse runs the same loop
//   on modulus-2, divide adds one more product; a zero inverse operand or divisor skips the loop
// one beat in flight; a new input beat can be taken in the cycle after the result beat leaves
// reset (synchronous, active low) returns to idle and restores the modulus
// ----------------------------------------------------------------------------
// modular arithmetic unit
// bit-serial add/sub/mul/pow/inverse/divide/equal over a configured modulus
// ----------------------------------------------------------------------------
`default_nettype none
module modular_arithmetic_unit
    import mau_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [30:0]  i_cfg_wdata,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: command[2:0], operand_a[33:3], operand_b[97:34], zero fill to 104
    input  wire  [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // tdata: result[30:0], is_equal[31]
    output logic [31:0]  m_axis_tdata
);
    localparam int EW = (EXP_BITS > 1) ? $clog2(EXP_BITS + 1) : 1;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0, S_REDA = 4'd1, S_REDB = 4'd2, S_DISP = 4'd3,
                           S_MUL  = 4'd4, S_PSTEP = 4'd5, S_PDONE = 4'd6,
                           S_OUT = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [DATA_W-1:0] r_mod;
    logic [DATA_W-1:0] m_eff;
    logic [CMD_W-1:0]  r_cmd;
    logic [BRAW_W-1:0] r_braw;
    logic [BRAW_W-1:0] r_sh;        // shift register feeding the reducer
    logic [6:0]        r_cnt;
    logic [DATA_W:0]   r_rem;       // running remainder
    logic [DATA_W-1:0] r_a, r_b;
    // power engine
    logic [DATA_W-1:0] r_acc, r_sq;
    logic [BRAW_W-1:0] r_exp;
    logic [EW-1:0]     r_ecnt;
    logic              r_phase;     // 0 acc*sq, 1 sq*sq
    logic              r_inv2;      // divide: inverse done, final multiply pending
    // serial multiplier: x*y mod m, msb of y first
    logic [DATA_W-1:0] r_mx, r_my;
    logic [DATA_W-1:0] r_mp;
    logic [4:0]        r_mcnt;
    logic [1:0]        r_mdst;      // 0 acc, 1 sq, 2 result
    logic [DATA_W-1:0] r_res;
    logic              r_eq;

    localparam logic [1:0] D_ACC = 2'd0, D_SQ = 2'd1, D_RES = 2'd2;

    assign m_eff = (r_mod < 31'd2) ? 31'd2 : r_mod;

    // reducer step: remainder*2 + bit, subtract once
    logic [DATA_W+1:0] red_t;
    logic [DATA_W:0]   red_n;
    assign red_t = {r_rem, r_sh[BRAW_W-1]};
    assign red_n = (red_t >= {2'b0, m_eff}) ? (DATA_W+1)'(red_t - {2'b0, m_eff})
                                            : red_t[DATA_W:0];

    // multiplier step: p = 2p (mod m) + (bit ? x : 0) (mod m)
    logic [DATA_W:0] mp2, mp2r, mp3;
    logic [DATA_W-1:0] mpn;
    assign mp2  = {r_mp, 1'b0};
    assign mp2r = (mp2 >= {1'b0, m_eff}) ? mp2 - {1'b0, m_eff} : mp2;
    assign mp3  = mp2r + (r_my[DATA_W-1] ? {1'b0, r_mx} : '0);
    assign mpn  = (mp3 >= {1'b0, m_eff}) ? DATA_W'(mp3 - {1'b0, m_eff}) : DATA_W'(mp3);

    // modular add / sub
    logic [DATA_W:0]   add_s, sub_s;
    assign add_s = {1'b0, r_a} + {1'b0, r_b};
    assign sub_s = {1'b0, r_a} + {1'b0, m_eff} - {1'b0, r_b};

    logic [DATA_W-1:0] one_m;
    assign one_m = 31'd1;          // effective modulus is at least 2

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {r_eq, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mod   <= MOD_RESET;
        end else begin
            if (i_cfg_we) r_mod <= i_cfg_wdata;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd  <= s_axis_tdata[2:0];
                        r_braw <= s_axis_tdata[97:34];
                        r_sh   <= {33'd0, s_axis_tdata[33:3]};
                        r_rem  <= '0;
                        r_cnt  <= 7'd0;
                        r_inv2 <= 1'b0;
                        r_state <= S_REDA;
                    end
                end
                S_REDA: begin
                    r_rem <= red_n;
                    r_sh  <= {r_sh[BRAW_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) begin
                        r_a   <= red_n[DATA_W-1:0];
                        r_sh  <= r_braw;
                        r_rem <= '0;
                        r_cnt <= 7'd0;
                        r_state <= S_REDB;
                    end
                end
                S_REDB: begin
                    r_rem <= red_n;
                    r_sh  <= {r_sh[BRAW_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) begin
                        r_b <= red_n[DATA_W-1:0];
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_res <= '0;
                    r_eq  <= 1'b0;
                    r_state <= S_OUT;
                    unique case (r_cmd) inside
                        CMD_ADD: r_res <= (add_s >= {1'b0, m_eff}) ?
                                          DATA_W'(add_s - {1'b0, m_eff}) : DATA_W'(add_s);
                        CMD_SUB: r_res <= (sub_s >= {1'b0, m_eff}) ?
                                          DATA_W'(sub_s - {1'b0, m_eff}) : DATA_W'(sub_s);
                        CMD_EQ:  r_eq  <= (r_a == r_b);
                        CMD_MUL: begin
                            r_mx <= r_a; r_my <= r_b; r_mp <= '0; r_mcnt <= '0;
                            r_mdst <= D_RES; r_state <= S_MUL;
                        end
                        CMD_POW: begin
                            r_acc <= one_m; r_sq <= r_a;
                            r_exp <= (EXP_BITS >= 64) ? r_braw
                                     : (r_braw & ((64'd1 << EXP_BITS) - 64'd1));
                            r_ecnt <= '0; r_phase <= 1'b0; r_state <= S_PSTEP;
                        end
                        CMD_INV, CMD_DIV: begin
                            if ((r_cmd == CMD_INV ? r_a : r_b) == '0) begin
                                r_res <= '0;
                            end else begin
                                r_acc <= one_m;
                                r_sq  <= (r_cmd == CMD_INV) ? r_a : r_b;
                                r_exp <= {33'd0, m_eff - 31'd2};
                                r_ecnt <= '0; r_phase <= 1'b0; r_state <= S_PSTEP;
                            end
                        end
                        default: ;
                    endcase
                end
                S_PSTEP: begin
                    // acc*sq when exponent bit set, then sq*sq
                    if (r_ecnt == EW'(EXP_BITS)) begin
                        r_state <= S_PDONE;
                    end else if (!r_phase) begin
                        r_phase <= 1'b1;
                        if (r_exp[0]) begin
                            r_mx <= r_acc; r_my <= r_sq; r_mp <= '0; r_mcnt <= '0;
                            r_mdst <= D_ACC; r_state <= S_MUL;
                        end
                    end else begin
                        r_phase <= 1'b0;
                        r_exp <= r_exp >> 1;
                        r_ecnt <= r_ecnt + EW'(1);
                        r_mx <= r_sq; r_my <= r_sq; r_mp <= '0; r_mcnt <= '0;
                        r_mdst <= D_SQ; r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_mp <= mpn;
                    r_my <= {r_my[DATA_W-2:0], 1'b0};
                    r_mcnt <= r_mcnt + 5'd1;
                    if (r_mcnt == 5'(DATA_W - 1)) begin
                        unique case (r_mdst)
                            D_ACC: begin r_acc <= mpn; r_state <= S_PSTEP; end
                            D_SQ:  begin r_sq  <= mpn; r_state <= S_PSTEP; end
                            default: begin r_res <= mpn; r_state <= S_OUT; end
                        endcase
                    end
                end
                S_PDONE: begin
                    if (r_cmd == CMD_DIV && !r_inv2) begin
                        r_inv2 <= 1'b1;
                        r_mx <= r_a; r_my <= r_acc; r_mp <= '0; r_mcnt <= '0;
                        r_mdst <= D_RES; r_state <= S_MUL;
                    end else begin
                        r_res <= r_acc; r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_eq_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[31] |-> r_cmd == CMD_EQ) else $error("eq flag");
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[30:0] < m_eff) else $error("range");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("overlap");
`endif
endmodule
`default_nettype wire
